/* sv/llre_pkg.sv */
// shared constants, types and the log2 mantissa rom for the laser line range estimator
package llre_pkg;

	// register indexes of the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFFSET_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_SLOPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_WIDTH = 3'd4;

	// reset values of the calibration registers
	localparam logic [31:0] OFFSET_A_RST = 32'd0;
	localparam logic [31:0] GAIN_B_RST = 32'd65536;
	localparam logic [15:0] HEIGHT_OFFSET_C_RST = 16'd0;
	localparam logic [15:0] TILT_SLOPE_RST = 16'd0;
	localparam logic [10:0] SCAN_WIDTH_RST = 11'd640;

	// log2 rom geometry, segment count is a power of two
	localparam int unsigned LOG_TABLE_ENTRIES = 256;
	localparam int unsigned LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES);
	localparam int unsigned FRAC_W = 30;
	localparam int unsigned LOG_REM_W = FRAC_W - LOG_IDX_W;
	localparam logic [63:0] ONE_Q30 = 64'd1 << FRAC_W;

	// ln 2 in q.24
	localparam logic signed [24:0] LN2_Q24 = 25'sd11629080;

	// offset of the input fraction bits (q.6) from the log exponent
	localparam logic [4:0] Q6_EXP = 5'd6;

	typedef logic [FRAC_W:0] log_rom_t [0:LOG_TABLE_ENTRIES];

	// log2(1 + k/N) in q0.30, truncated, bit by bit through repeated squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t rom;
		logic [63:0] v;
		logic [FRAC_W-1:0] r;
		for (int k = 0; k <= int'(LOG_TABLE_ENTRIES); k++) begin
			if (k == int'(LOG_TABLE_ENTRIES)) begin
				rom[k] = (FRAC_W+1)'(ONE_Q30);
			end else begin
				v = ONE_Q30 + (64'(k) << LOG_REM_W);
				r = '0;
				for (int b = FRAC_W - 1; b >= 0; b--) begin
					v = (v * v) >> FRAC_W;
					if (v >= (ONE_Q30 << 1)) begin
						v = v >> 1;
						r[b] = 1'b1;
					end
				end
				rom[k] = {1'b0, r};
			end
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

/* sv/laser_line_range_estimator_unit.sv */
// top level of the laser line range estimator: eight-stage range pipeline
// The block takes one column request per clock unless stalled and presents its range
// through an eight-stage pipeline: centring and tilt multiply, height correction,
// leading-one normalize, log2 rom lookup, interpolation multiply, ln 2 multiply, gain
// multiply, offset add with saturation. Each stage holds one request, so the sustained
// rate is one column per clock while out_ready stays high; a low out_ready with out_valid
// high freezes every stage and in_ready follows it. range_valid and range_cm are 0 when
// line_height is zero or the corrected height is not positive. Calibration registers are
// written through cfg_we/cfg_index/cfg_wdata and must only change while the pipe is empty.
module laser_line_range_estimator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  column,
	input  logic [15:0] line_height,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  column_out,
	output logic signed [31:0] range_cm,
	output logic        range_valid
);

	localparam int unsigned IW = llre_pkg::LOG_IDX_W;
	localparam int unsigned RW = llre_pkg::LOG_REM_W;
	localparam int unsigned FW = llre_pkg::FRAC_W;

	// calibration registers
	logic signed [31:0] offset_a_q;
	logic signed [31:0] gain_b_q;
	logic signed [15:0] height_offset_c_q;
	logic signed [15:0] tilt_slope_q;
	logic [10:0]        scan_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_a_q        <= llre_pkg::OFFSET_A_RST;
			gain_b_q          <= llre_pkg::GAIN_B_RST;
			height_offset_c_q <= llre_pkg::HEIGHT_OFFSET_C_RST;
			tilt_slope_q      <= llre_pkg::TILT_SLOPE_RST;
			scan_width_q      <= llre_pkg::SCAN_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				llre_pkg::REG_OFFSET_A:        offset_a_q <= cfg_wdata;
				llre_pkg::REG_GAIN_B:          gain_b_q <= cfg_wdata;
				llre_pkg::REG_HEIGHT_OFFSET_C: height_offset_c_q <= cfg_wdata[15:0];
				llre_pkg::REG_TILT_SLOPE:      tilt_slope_q <= cfg_wdata[15:0];
				llre_pkg::REG_SCAN_WIDTH:      scan_width_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// global advance: the whole pipe moves unless the output request is stalled
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// valid bits of each stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			out_valid <= v_s7;
		end
	end

	// stage 1: centred column in half pixels times tilt slope
	logic signed [11:0] x2;
	logic signed [27:0] tilt_prod;
	logic signed [27:0] tilt_prod_s1;
	logic [15:0]        height_s1;
	logic [9:0]         col_s1;

	assign x2        = $signed({1'b0, column, 1'b0}) - $signed({1'b0, scan_width_q});
	assign tilt_prod = x2 * tilt_slope_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			tilt_prod_s1 <= tilt_prod;
			height_s1    <= line_height;
			col_s1       <= column;
		end
	end

	// stage 2: rounded tilt, corrected height
	logic signed [27:0] tilt_round;
	logic signed [20:0] arg;
	logic signed [20:0] arg_s2;
	logic               ok_s2;
	logic [9:0]         col_s2;

	assign tilt_round = (tilt_prod_s1 + 28'sd256) >>> 9;
	assign arg = $signed({5'b0, height_s1}) - 21'(tilt_round) - 21'(height_offset_c_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_s2 <= arg;
			ok_s2  <= (height_s1 != 16'd0);
			col_s2 <= col_s1;
		end
	end

	// stage 3: leading-one position and normalized fraction
	logic [18:0]   ua;
	logic [4:0]    lead;
	logic [48:0]   norm;
	logic          pos;
	logic [4:0]    p_s3;
	logic [FW-1:0] frac_s3;
	logic          ok_s3;
	logic [9:0]    col_s3;

	assign ua  = arg_s2[18:0];
	assign pos = !arg_s2[20] && (arg_s2 != 21'sd0);

	always_comb begin
		lead = '0;
		for (int b = 0; b < 19; b++) begin
			if (ua[b]) lead = 5'(b);
		end
	end

	assign norm = {ua, 30'b0} >> lead;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= lead;
			frac_s3 <= norm[FW-1:0];
			ok_s3   <= ok_s2 && pos;
			col_s3  <= col_s2;
		end
	end

	// stage 4: rom lookup of the segment ends
	logic [IW-1:0] seg;
	logic [IW:0]   seg_lo;
	logic [IW:0]   seg_hi;
	logic [FW:0]   lo_s4;
	logic [FW:0]   hi_s4;
	logic [RW-1:0] rem_s4;
	logic [4:0]    p_s4;
	logic          ok_s4;
	logic [9:0]    col_s4;

	assign seg    = frac_s3[FW-1 -: IW];
	assign seg_lo = {1'b0, seg};
	assign seg_hi = seg_lo + (IW+1)'(1);

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s4  <= llre_pkg::LOG_ROM[seg_lo];
			hi_s4  <= llre_pkg::LOG_ROM[seg_hi];
			rem_s4 <= frac_s3[RW-1:0];
			p_s4   <= p_s3;
			ok_s4  <= ok_s3;
			col_s4 <= col_s3;
		end
	end

	// stage 5: linear interpolation inside the segment
	logic [FW:0]      seg_diff;
	logic [FW+RW:0]   interp_prod;
	logic [FW:0]      mant_sum;
	logic [FW-1:0]    mant_s5;
	logic [4:0]       p_s5;
	logic             ok_s5;
	logic [9:0]       col_s5;

	assign seg_diff    = hi_s4 - lo_s4;
	assign interp_prod = seg_diff * rem_s4;
	assign mant_sum    = lo_s4 + interp_prod[FW+RW:RW];

	always_ff @(posedge clk) begin
		if (adv) begin
			mant_s5 <= mant_sum[FW-1:0];
			p_s5    <= p_s4;
			ok_s5   <= ok_s4;
			col_s5  <= col_s4;
		end
	end

	// stage 6: log2 to natural log, floor to q6.16
	logic [4:0]          exp_adj;
	logic signed [34:0]  l2;
	logic signed [59:0]  ln_prod;
	logic signed [21:0]  lnq_s6;
	logic                ok_s6;
	logic [9:0]          col_s6;

	assign exp_adj = p_s5 - llre_pkg::Q6_EXP;
	assign l2      = $signed({exp_adj, mant_s5});
	assign ln_prod = l2 * llre_pkg::LN2_Q24;

	always_ff @(posedge clk) begin
		if (adv) begin
			lnq_s6 <= ln_prod[59:38];
			ok_s6  <= ok_s5;
			col_s6 <= col_s5;
		end
	end

	// stage 7: gain multiply, floor shift by 16
	logic signed [53:0] gain_prod;
	logic signed [37:0] scaled_s7;
	logic               ok_s7;
	logic [9:0]         col_s7;

	assign gain_prod = gain_b_q * lnq_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s7 <= gain_prod[53:16];
			ok_s7     <= ok_s6;
			col_s7    <= col_s6;
		end
	end

	// stage 8: offset add, saturation and output register
	logic signed [38:0] range_sum;
	logic signed [31:0] range_sat;

	assign range_sum = 39'(offset_a_q) + 39'(scaled_s7);

	always_comb begin
		if (range_sum > 39'sd2147483647) begin
			range_sat = 32'sh7FFF_FFFF;
		end else if (range_sum < -39'sd2147483648) begin
			range_sat = 32'sh8000_0000;
		end else begin
			range_sat = range_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			column_out  <= col_s7;
			range_cm    <= ok_s7 ? range_sat : 32'sd0;
			range_valid <= ok_s7;
		end
	end

	// an invalid range always reads as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_valid |-> range_cm == 32'sd0)
		else $error("invalid range result is not zero");

	// interpolated mantissa never carries into the exponent
	a_mant_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ok_s4 |-> !mant_sum[FW] && (hi_s4 >= lo_s4))
		else $error("log2 mantissa overflow");

	// a stalled pipe keeps the request in the last internal stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !adv |=> v_s7 && $stable(scaled_s7) && $stable(col_s7) && $stable(ok_s7))
		else $error("stage 7 lost its request during a stall");

endmodule
